### src/text_console_writer_assert.svh
// Assertion macros for the text console writer.
// Included by the top level; no other dependency.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked only while out of reset.
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define TCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### src/tcw_pkg.sv
// Package for the text console writer: screen geometry, character codes,
// micro-step codes, control word type and the microcode ROM. No dependencies.
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 60;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int KEEP    = (ROWS - 1) * COLUMNS;

  localparam int ROW_W  = 6;
  localparam int COL_W  = 7;
  localparam int ADDR_W = 13;
  localparam int CHAR_W = 8;

  localparam int IN_W  = 24;
  localparam int OUT_W = 24;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CHAR_W-1:0] SPACE_CODE = 8'd32;
  localparam logic [CHAR_W-1:0] CLEAR_CODE = 8'd12;
  localparam logic [CHAR_W-1:0] LF_CODE    = 8'd10;
  localparam logic [CHAR_W-1:0] CR_CODE    = 8'd13;

  // Micro-step codes.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] S_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] S_READ   = 4'd1;
  localparam logic [STEP_W-1:0] S_PUT    = 4'd2;
  localparam logic [STEP_W-1:0] S_NL     = 4'd3;
  localparam logic [STEP_W-1:0] S_SCR0   = 4'd4;
  localparam logic [STEP_W-1:0] S_SCR_RD = 4'd5;
  localparam logic [STEP_W-1:0] S_SCR_WR = 4'd6;
  localparam logic [STEP_W-1:0] S_CLR    = 4'd7;
  localparam logic [STEP_W-1:0] S_FILL   = 4'd8;
  localparam logic [STEP_W-1:0] S_POST   = 4'd9;
  localparam logic [STEP_W-1:0] S_DONE   = 4'd10;

  typedef enum logic [3:0] {
    A_NONE,
    A_ACCEPT,
    A_READ_CELL,
    A_PUT,
    A_NEWLINE,
    A_PTR_ZERO,
    A_READ_SHIFT,
    A_WRITE_SHIFT,
    A_HOME,
    A_FILL,
    A_END_INIT,
    A_RESULT
  } act_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_DISPATCH,
    C_COL_WRAP,
    C_ROW_LAST,
    C_KEEP_LAST,
    C_CELLS_LAST,
    C_INIT,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    act_t              act;
    cond_t             cond;
    logic [STEP_W-1:0] tgt_true;
    logic [STEP_W-1:0] tgt_false;
  } uword_t;

  // Microcode ROM: outside C_DISPATCH, next step is tgt_true if cond holds.
  function automatic uword_t ucode_word(input logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      S_IDLE:   w = '{A_ACCEPT,      C_DISPATCH,   S_IDLE,   S_IDLE};
      S_READ:   w = '{A_READ_CELL,   C_ALWAYS,     S_DONE,   S_DONE};
      S_PUT:    w = '{A_PUT,         C_COL_WRAP,   S_NL,     S_DONE};
      S_NL:     w = '{A_NEWLINE,     C_ROW_LAST,   S_SCR0,   S_DONE};
      S_SCR0:   w = '{A_PTR_ZERO,    C_ALWAYS,     S_SCR_RD, S_SCR_RD};
      S_SCR_RD: w = '{A_READ_SHIFT,  C_ALWAYS,     S_SCR_WR, S_SCR_WR};
      S_SCR_WR: w = '{A_WRITE_SHIFT, C_KEEP_LAST,  S_FILL,   S_SCR_RD};
      S_CLR:    w = '{A_HOME,        C_ALWAYS,     S_FILL,   S_FILL};
      S_FILL:   w = '{A_FILL,        C_CELLS_LAST, S_POST,   S_FILL};
      S_POST:   w = '{A_END_INIT,    C_INIT,       S_IDLE,   S_DONE};
      S_DONE:   w = '{A_RESULT,      C_OUT_BUSY,   S_DONE,   S_IDLE};
      default:  w = '{A_NONE,        C_ALWAYS,     S_IDLE,   S_IDLE};
    endcase
    return w;
  endfunction

endpackage

### src/text_console_writer.sv
// Text console writer: 60 x 80 screen store with a cursor, run by a microcoded sequencer.
// A read, a plain character or a newline without scroll runs its own micro-step, then
// S_DONE registers the result; a character in the last column also runs S_NL.
// A scroll copies the store up one row by a read step and a write step per cell, then
// blanks the bottom row; a clear homes the cursor and fills every cell with spaces.
// After reset a clearing pass holds in_tready low; a transaction is taken only in S_IDLE. Uses tcw_pkg.
`include "text_console_writer_assert.svh"

module text_console_writer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // opcode [0], char_code [8:1], cell_address [21:9], zero padding [23:22]
  input  logic [tcw_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // cursor_row [5:0], cursor_column [12:6], read_data [20:13], zero padding [23:21]
  output logic [tcw_pkg::OUT_W-1:0] out_tdata
);
  import tcw_pkg::*;

  logic [STEP_W-1:0] upc_r, upc_nxt;
  logic              init_r, init_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;

  logic              item_op_r;
  logic [CHAR_W-1:0] item_char_r;
  logic [ADDR_W-1:0] item_addr_r;

  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r;

  logic [CHAR_W-1:0] mem [CELLS];
  logic [CHAR_W-1:0] rd_data_r;

  uword_t            uw;
  logic              cond_ok;
  logic              accept;
  logic              out_free;
  logic              addr_ok;
  logic [STEP_W-1:0] dispatch_tgt;
  logic [ADDR_W-1:0] put_addr;

  logic              in_op;
  logic [CHAR_W-1:0] in_char;
  logic [ADDR_W-1:0] in_addr;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  assign in_op   = in_tdata[0];
  assign in_char = in_tdata[8:1];
  assign in_addr = in_tdata[21:9];

  assign uw        = ucode_word(upc_r);
  assign in_tready = (upc_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign addr_ok   = (item_addr_r < ADDR_W'(CELLS));
  assign put_addr  = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);

  always_comb begin
    if (in_op == OP_READ) begin
      dispatch_tgt = S_READ;
    end else if (in_char == CLEAR_CODE) begin
      dispatch_tgt = S_CLR;
    end else if (in_char inside {LF_CODE, CR_CODE}) begin
      dispatch_tgt = S_NL;
    end else begin
      dispatch_tgt = S_PUT;
    end
  end

  always_comb begin
    case (uw.cond)
      C_ALWAYS:     cond_ok = 1'b1;
      C_DISPATCH:   cond_ok = accept;
      C_COL_WRAP:   cond_ok = (col_r == COL_W'(COLUMNS - 1));
      C_ROW_LAST:   cond_ok = (row_r == ROW_W'(ROWS - 1));
      C_KEEP_LAST:  cond_ok = (ptr_r == ADDR_W'(KEEP - 1));
      C_CELLS_LAST: cond_ok = (ptr_r == ADDR_W'(CELLS - 1));
      C_INIT:       cond_ok = init_r;
      C_OUT_BUSY:   cond_ok = !out_free;
      default:      cond_ok = 1'b1;
    endcase
  end

  always_comb begin
    if (uw.cond == C_DISPATCH) begin
      upc_nxt = accept ? dispatch_tgt : S_IDLE;
    end else begin
      upc_nxt = cond_ok ? uw.tgt_true : uw.tgt_false;
    end
  end

  // Datapath control decoded from the current micro-operation.
  always_comb begin
    init_nxt      = init_r;
    ptr_nxt       = ptr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r;
    mem_wdata     = SPACE_CODE;
    mem_re        = 1'b0;
    mem_raddr     = item_addr_r;
    case (uw.act)
      A_READ_CELL: begin
        mem_re = addr_ok;
      end
      A_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = put_addr;
        mem_wdata = item_char_r;
        col_nxt   = col_r + COL_W'(1);
      end
      A_NEWLINE: begin
        col_nxt = '0;
        if (row_r != ROW_W'(ROWS - 1)) begin
          row_nxt = row_r + ROW_W'(1);
        end
      end
      A_PTR_ZERO: begin
        ptr_nxt = '0;
      end
      A_READ_SHIFT: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_r + ADDR_W'(COLUMNS);
      end
      A_WRITE_SHIFT: begin
        mem_we    = 1'b1;
        mem_wdata = rd_data_r;
        ptr_nxt   = ptr_r + ADDR_W'(1);
      end
      A_HOME: begin
        ptr_nxt = '0;
        row_nxt = '0;
        col_nxt = '0;
      end
      A_FILL: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + ADDR_W'(1);
      end
      A_END_INIT: begin
        init_nxt = 1'b0;
      end
      A_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= S_FILL;
      init_r      <= 1'b1;
      ptr_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      init_r      <= init_nxt;
      ptr_r       <= ptr_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_op_r   <= in_op;
      item_char_r <= in_char;
      item_addr_r <= in_addr;
    end
    if (uw.act == A_RESULT && out_free) begin
      out_data_r <= {3'b000,
                     (item_op_r == OP_READ && addr_ok) ? rd_data_r : CHAR_W'(0),
                     col_r, row_r};
    end
  end

  // Screen store: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `TCW_ASSERT(a_row_range, clk, rst_n, (row_r <= ROW_W'(ROWS - 1)), "cursor row out of range")
  `TCW_ASSERT(a_col_range, clk, rst_n, (upc_r == S_IDLE) |-> (col_r < COL_W'(COLUMNS)), "cursor column out of range when idle")
  `TCW_ASSERT(a_accept_leaves_idle, clk, rst_n, accept |=> (upc_r != S_IDLE), "sequencer stayed idle after a transaction")
  `TCW_ASSERT(a_write_in_store, clk, rst_n, mem_we |-> (mem_waddr < ADDR_W'(CELLS)), "store write outside the screen")
  `TCW_ASSERT_ALWAYS(a_no_accept_in_init, clk, init_r |-> !in_tready, "input accepted during the clearing pass")

endmodule
